### design/sap_pkg.sv
// Types and constants for the sweep-and-prune pair finder.
// No dependencies; every other design file imports this package.
package sap_pkg;

  localparam int CoordBits = 16;
  localparam int IdBits    = 12;
  localparam int KindBits  = 2;

  typedef struct packed {
    logic                        frame_start;
    logic signed [CoordBits-1:0] box_min_x;
    logic signed [CoordBits-1:0] box_min_y;
    logic signed [CoordBits-1:0] box_max_x;
    logic signed [CoordBits-1:0] box_max_y;
    logic [IdBits-1:0]           box_id;
    logic [KindBits-1:0]         box_kind;
  } sap_in_t;

  typedef struct packed {
    logic                pair_valid;
    logic [IdBits-1:0]   new_id;
    logic [IdBits-1:0]   old_id;
    logic [KindBits-1:0] new_kind;
    logic [KindBits-1:0] old_kind;
    logic                run_last;
    logic                list_overflow;
  } sap_out_t;

  // One entry of the active list.
  typedef struct packed {
    logic signed [CoordBits-1:0] max_x;
    logic signed [CoordBits-1:0] min_y;
    logic signed [CoordBits-1:0] max_y;
    logic [IdBits-1:0]           id;
    logic [KindBits-1:0]         kind;
  } sap_slot_t;

endpackage

### design/sap_cell.sv
// One cell of the active-list chain: holds one entry, shifts toward the head
// or loads a new entry. Depends on sap_pkg.
module sap_cell (
  input  logic              clk,
  input  logic              shift_en,
  input  sap_pkg::sap_slot_t shift_in,
  input  logic              load_en,
  input  sap_pkg::sap_slot_t load_data,
  output sap_pkg::sap_slot_t slot_q
);
  import sap_pkg::*;

  sap_slot_t slot_r;
  sap_slot_t slot_nxt;

  always_comb begin
    slot_nxt = slot_r;
    if (load_en) begin
      slot_nxt = load_data;
    end else if (shift_en) begin
      slot_nxt = shift_in;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

  assign slot_q = slot_r;

endmodule

### design/sweep_and_prune_pairs.sv
// Sweep-and-prune broad phase along x over a chain of list cells.
// Each item is accepted in idle, then every listed box leaves the head cell in
// turn during the scan, the scan's end is seen, and a closing step emits the
// run-last result; output stalls can hold the scan and the close. A frame start
// empties the list first. One item at a time: in_stall is high until it is done.
// Reset (rst_n low, synchronous) empties the active list and the output register.
module sweep_and_prune_pairs #(
  parameter int ACTIVE_SLOTS = 32,
  parameter int ID_BITS      = 12
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  sap_pkg::sap_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output sap_pkg::sap_out_t out_data
);
  import sap_pkg::*;

  localparam int LenBits = $clog2(ACTIVE_SLOTS + 1);
  localparam int IdxBits = (ACTIVE_SLOTS > 1) ? $clog2(ACTIVE_SLOTS) : 1;
  localparam int KeepId  = (ID_BITS < IdBits) ? ID_BITS : IdBits;
  localparam logic [IdBits-1:0] IdMask = IdBits'((1 << KeepId) - 1);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StScan  = 2'd1;
  localparam logic [1:0] StClose = 2'd2;

  // The list is a queue whose head is cell 0. During a scan each listed box
  // leaves the head while the whole chain shifts one cell toward the head;
  // a box that survives pruning is written back at the tail. After as many
  // steps as the list held, the survivors sit in their original order.
  logic [1:0]         state_r, state_nxt;
  logic [LenBits-1:0] len_r, len_nxt;
  logic [LenBits-1:0] left_r, left_nxt;
  sap_in_t            box_r, box_nxt;
  logic               out_valid_r, out_valid_nxt;
  sap_out_t           out_data_r, out_data_nxt;

  sap_slot_t cell_q   [ACTIVE_SLOTS];
  logic      shift_en;
  logic      load_en;
  logic [IdxBits-1:0] load_idx;
  sap_slot_t load_data;

  sap_slot_t head;
  logic      out_free;
  logic      keep;
  logic      overlap;
  sap_slot_t new_slot;

  assign head     = cell_q[0];
  assign out_free = !out_valid_r || !out_stall;
  // An active box whose right edge equals the new left edge is kept.
  assign keep     = !(head.max_x < box_r.box_min_x);
  // Boxes that only touch in y do not pair.
  assign overlap  = (box_r.box_max_y > head.min_y) && (box_r.box_min_y < head.max_y);

  assign new_slot.max_x = box_r.box_max_x;
  assign new_slot.min_y = box_r.box_min_y;
  assign new_slot.max_y = box_r.box_max_y;
  assign new_slot.id    = box_r.box_id & IdMask;
  assign new_slot.kind  = box_r.box_kind;

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    left_nxt      = left_r;
    box_nxt       = box_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    shift_en      = 1'b0;
    load_en       = 1'b0;
    load_idx      = '0;
    load_data     = head;
    case (state_r)
      StIdle: begin
        if (in_valid) begin
          box_nxt   = in_data;
          state_nxt = StScan;
          if (in_data.frame_start) begin
            len_nxt  = '0;
            left_nxt = '0;
          end else begin
            left_nxt = len_r;
          end
        end
      end
      StScan: begin
        if (left_r == '0) begin
          state_nxt = StClose;
        end else if (out_free || !(keep && overlap)) begin
          // Pop the head box; the chain moves up one cell.
          shift_en = 1'b1;
          left_nxt = left_r - 1'b1;
          if (keep) begin
            load_en  = 1'b1;
            load_idx = IdxBits'(len_r - 1'b1);
            if (overlap) begin
              out_valid_nxt              = 1'b1;
              out_data_nxt.pair_valid    = 1'b1;
              out_data_nxt.new_id        = box_r.box_id & IdMask;
              out_data_nxt.old_id        = head.id;
              out_data_nxt.new_kind      = box_r.box_kind;
              out_data_nxt.old_kind      = head.kind;
              out_data_nxt.run_last      = 1'b0;
              out_data_nxt.list_overflow = 1'b0;
            end
          end else begin
            len_nxt = len_r - 1'b1;
          end
        end
      end
      StClose: begin
        if (out_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.pair_valid    = 1'b0;
          out_data_nxt.new_id        = box_r.box_id & IdMask;
          out_data_nxt.old_id        = '0;
          out_data_nxt.new_kind      = box_r.box_kind;
          out_data_nxt.old_kind      = '0;
          out_data_nxt.run_last      = 1'b1;
          out_data_nxt.list_overflow = (len_r == LenBits'(ACTIVE_SLOTS));
          if (len_r != LenBits'(ACTIVE_SLOTS)) begin
            load_en   = 1'b1;
            load_idx  = IdxBits'(len_r);
            load_data = new_slot;
            len_nxt   = len_r + 1'b1;
          end
          state_nxt = StIdle;
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  for (genvar i = 0; i < ACTIVE_SLOTS; i++) begin : g_cell
    sap_slot_t nb;
    if (i == ACTIVE_SLOTS - 1) begin : g_tail
      assign nb = cell_q[i];
    end else begin : g_mid
      assign nb = cell_q[i+1];
    end
    sap_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .shift_in (nb),
      .load_en  (load_en && (load_idx == IdxBits'(i))),
      .load_data(load_data),
      .slot_q   (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= StIdle;
      len_r       <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    box_r      <= box_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != StIdle);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### tb/tb.sv
// Self-checking testbench for sweep_and_prune_pairs: box transactions in,
// pair and closing transactions out. Depends on sap_pkg and the block RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sap_pkg::*;

  localparam int Slots = 32;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  sap_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  sap_out_t out_data;

  sweep_and_prune_pairs #(.ACTIVE_SLOTS(Slots), .ID_BITS(IdBits)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // The predictor keeps its own copy of the active list, in insertion order.
  sap_slot_t sweep_list[$];
  sap_out_t  pending_pairs[$];

  int mismatches = 0;
  int sent_boxes = 0;
  int pairs_seen = 0;
  int overflows_seen = 0;
  bit calm = 1'b0;       // when set, neither side idles
  bit hold_off = 1'b0;   // receiver refuses everything while set

  // Prune, search and append exactly as the block does, queueing the
  // transactions the block has to produce for this box.
  function automatic void predict_box(sap_in_t b);
    sap_slot_t kept[$];
    sap_out_t  r;
    sap_slot_t s;
    if (b.frame_start) sweep_list.delete();
    foreach (sweep_list[i])
      if (!(sweep_list[i].max_x < b.box_min_x)) kept = {kept, sweep_list[i]};
    sweep_list = kept;
    foreach (sweep_list[i]) begin
      if (b.box_max_y > sweep_list[i].min_y && b.box_min_y < sweep_list[i].max_y) begin
        r = '0;
        r.pair_valid = 1'b1;
        r.new_id = b.box_id;
        r.old_id = sweep_list[i].id;
        r.new_kind = b.box_kind;
        r.old_kind = sweep_list[i].kind;
        pending_pairs = {pending_pairs, r};
      end
    end
    r = '0;
    r.new_id = b.box_id;
    r.new_kind = b.box_kind;
    r.run_last = 1'b1;
    if (sweep_list.size() < Slots) begin
      s.max_x = b.box_max_x;
      s.min_y = b.box_min_y;
      s.max_y = b.box_max_y;
      s.id    = b.box_id;
      s.kind  = b.box_kind;
      sweep_list = {sweep_list, s};
    end else begin
      r.list_overflow = 1'b1;
    end
    pending_pairs = {pending_pairs, r};
  endfunction

  // Offer one box, with an optional random gap first, and hold it until taken.
  // Valid stays high after acceptance so that the next box can follow at once;
  // callers that pause drop it themselves.
  task automatic send_box(sap_in_t b);
    if (!calm) begin
      if ($urandom_range(99) < 27) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while ($urandom_range(99) < 27) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_box(b);
    sent_boxes++;
  endtask

  // Receiver stall pattern: random idling, a calm stretch, or a long hold-off.
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= hold_off || (!calm && $urandom_range(99) < 27);
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    sap_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pairs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        want = pending_pairs.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, out_data);
        end
        if (want.pair_valid) pairs_seen++;
        if (want.list_overflow) overflows_seen++;
      end
    end
  end

  function automatic sap_in_t make_box(bit fs, int mnx, int mny, int mxx, int mxy,
                                       int id, int kind);
    sap_in_t b;
    b.frame_start = fs;
    b.box_min_x = mnx[15:0];
    b.box_min_y = mny[15:0];
    b.box_max_x = mxx[15:0];
    b.box_max_y = mxy[15:0];
    b.box_id = id[11:0];
    b.box_kind = kind[1:0];
    return b;
  endfunction

  // Extremes, touching edges, inverted boxes and out-of-order input.
  task automatic test_edges();
    send_box(make_box(1, -32768, -32768, 32767, 32767, 4095, 3));
    send_box(make_box(0, -32768, -32768, 32767, 32767, 0, 0));
    send_box(make_box(0, 100, 32767, 200, -32768, 1, 1));    // inverted
    send_box(make_box(0, 0, 10, 50, 20, 2, 2));
    send_box(make_box(0, 10, 20, 60, 30, 3, 1));             // y just touches
    send_box(make_box(1, 0, 0, 16, 16, 4, 0));
    send_box(make_box(0, 16, 8, 32, 24, 5, 3));               // x edge kept
    send_box(make_box(0, 17, 0, 40, 10, 6, 2));               // first box pruned
    send_box(make_box(0, -500, -5, -400, 5, 7, 1));           // unsorted
    send_box(make_box(0, 32767, -1, 32767, 1, 2730, 2));
  endtask

  // Fill the list past its capacity with boxes that all overlap.
  task automatic test_full_list();
    send_box(make_box(1, 0, 0, 1000, 1000, 100, 1));
    for (int i = 1; i < Slots + 3; i++)
      send_box(make_box(0, i, i, 1000, 1000, 100 + i, i % 4));
  endtask

  // Mostly well-formed frames with ascending min x; some noise boxes.
  task automatic test_random_frames(int count);
    int x = 0;
    int w, y, h;
    for (int n = 0; n < count; n++) begin
      bit fs = (n == 0) || ($urandom_range(99) < 6);
      if (fs) x = $urandom_range(65535) - 32768;
      if ($urandom_range(99) < 10) begin
        send_box(make_box(fs, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom));
      end else begin
        x = x + $urandom_range(40);
        if (x > 32767) x = 32767;
        w = $urandom_range(300);
        y = $urandom_range(2000) - 1000;
        h = $urandom_range(400);
        send_box(make_box(fs, x, y, x + w > 32767 ? 32767 : x + w, y + h,
                          $urandom, $urandom));
      end
    end
  endtask

  // Receiver holds off while boxes keep coming, so the block backs up.
  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (150) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random_frames(12);
    join
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edges();
    test_full_list();
    test_backpressure();
    calm = 1'b1;
    test_random_frames(40);
    calm = 1'b0;
    test_random_frames(100);
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (Slots + 10) @(posedge clk);
    $display("Sent %0d boxes; checked %0d pairs and %0d list overflows.",
             sent_boxes, pairs_seen, overflows_seen);
    if (mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #5ms;
    $display("end of test: mismatches");
    $finish;
  end
endmodule
